// ===== design/htc_pkg.sv =====
`timescale 1ns / 1ps
package htc_pkg;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_ENCODE  = 3'd1,
    OP_DECODE  = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_RESTART = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_ENCODED = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_DECODED = 3'd4,
    ST_MORE    = 3'd5,
    ST_TOOLONG = 3'd6,
    ST_CLEARED = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

  // search request travelling down the chain
  typedef struct packed {
    logic        encode;
    logic [7:0]  symbol;
    logic [15:0] code;
    logic [4:0]  length;
  } probe_t;

  // hit travelling down the chain
  typedef struct packed {
    logic        hit;
    logic [7:0]  symbol;
    logic [15:0] code;
    logic [4:0]  length;
  } hit_t;

endpackage

// ===== design/htc_cell.sv =====
`timescale 1ns / 1ps
module htc_cell
  import htc_pkg::*;
(
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [7:0]  ld_symbol_i,
  input  logic [15:0] ld_code_i,
  input  logic [4:0]  ld_length_i,
  input  logic        active_i,
  input  probe_t      probe_i,
  input  hit_t        hit_i,
  output probe_t      probe_o,
  output hit_t        hit_o
);

  logic [7:0]  sym_q;
  logic [15:0] code_q;
  logic [4:0]  len_q;
  logic        match;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sym_q  <= ld_symbol_i;
      code_q <= ld_code_i;
      len_q  <= ld_length_i;
    end
  end

  // compare against the probe
  always_comb begin
    if (probe_i.encode) begin
      match = (sym_q == probe_i.symbol);
    end else begin
      match = (len_q == probe_i.length) && (code_q == probe_i.code);
    end
  end

  // first hit in load order is kept
  always_ff @(posedge clk_i) begin
    probe_o <= probe_i;
    if (!hit_i.hit && active_i && match) begin
      hit_o <= '{hit: 1'b1, symbol: sym_q, code: code_q, length: len_q};
    end else begin
      hit_o <= hit_i;
    end
  end

endmodule

// ===== design/huffman_table_codec_core.sv =====
`timescale 1ns / 1ps
// load, clear, restart and unused codes: result strobe in the cycle after acceptance
// encode and decode: result strobe once the probe, registered at the chain head, has
// walked the cell chain one cell per cycle
// busy is high after acceptance through the result strobe
// reset empties the table and the decode accumulator; results cannot be stalled
module huffman_table_codec_core
  import htc_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_LEN  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  symbol_i,
  input  logic [15:0] code_word_i,
  input  logic [4:0]  code_length_i,
  input  logic        bit_in_i,
  output logic        strobe,
  output logic [2:0]  status_o,
  output logic [7:0]  symbol_out_o,
  output logic [15:0] code_out_o,
  output logic [4:0]  length_out_o
);

  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int LenCap = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
  localparam int PendW = LenCap;

  fsm_e            state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] timer_q;
  logic [PendW-1:0] pend_q;
  logic [5:0]      plen_q;
  logic [2:0]      op_q;
  logic            full_q;
  logic            full;
  logic            accept;
  logic [4:0]      ld_len;
  logic [15:0]     ld_code;
  logic [16:0]     shifted;
  logic [15:0]     pbits;
  logic [5:0]      plen_new;

  probe_t          probe_c [TABLE_ENTRIES+1];
  hit_t            hit_c   [TABLE_ENTRIES+1];

  assign accept = start && !busy;
  assign full   = (count_q == CntW'(TABLE_ENTRIES));

  // clamped load fields
  always_comb begin
    ld_len = (code_length_i > 5'(LenCap)) ? 5'(LenCap) : code_length_i;
    ld_code = code_word_i & 16'((17'd1 << ld_len) - 17'd1);
  end

  // accumulator after this bit
  assign shifted  = {1'b0, 16'(pend_q)} << 1;
  assign pbits    = (shifted[15:0] | {15'd0, bit_in_i}) & 16'((17'd1 << PendW) - 17'd1);
  assign plen_new = plen_q + 6'd1;

  // chain head; a length beyond any stored code can never match
  always_ff @(posedge clk_i) begin
    if (accept) begin
      probe_c[0] <= '{encode: (operation_i == OP_ENCODE), symbol: symbol_i,
                      code: pbits,
                      length: (plen_new > 6'd16) ? 5'd31 : plen_new[4:0]};
    end
    hit_c[0] <= '0;
  end

  // row of cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    htc_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (accept && operation_i == OP_LOAD && !full &&
                    count_q[IdxW-1:0] == IdxW'(g)),
      .ld_symbol_i (symbol_i),
      .ld_code_i   (ld_code),
      .ld_length_i (ld_len),
      .active_i    (count_q > CntW'(g)),
      .probe_i     (probe_c[g]),
      .hit_i       (hit_c[g]),
      .probe_o     (probe_c[g+1]),
      .hit_o       (hit_c[g+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (accept) begin
        state_d = (operation_i == OP_ENCODE || operation_i == OP_DECODE) ? FSM_SCAN
                                                                         : FSM_DONE;
      end
      FSM_SCAN: if (timer_q == CntW'(TABLE_ENTRIES)) state_d = FSM_IDLE;
      FSM_DONE: state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state_q != FSM_IDLE);
    strobe = (state_q == FSM_DONE) ||
             (state_q == FSM_SCAN && timer_q == CntW'(TABLE_ENTRIES));
    status_o = ST_CLEARED;
    symbol_out_o = '0;
    code_out_o = '0;
    length_out_o = '0;
    case (op_q)
      OP_LOAD: status_o = full_q ? ST_FULL : ST_LOADED;
      OP_ENCODE: begin
        if (hit_c[TABLE_ENTRIES].hit) begin
          status_o = ST_ENCODED;
          code_out_o = hit_c[TABLE_ENTRIES].code;
          length_out_o = hit_c[TABLE_ENTRIES].length;
        end else begin
          status_o = ST_UNKNOWN;
        end
      end
      OP_DECODE: begin
        if (hit_c[TABLE_ENTRIES].hit) begin
          status_o = ST_DECODED;
          symbol_out_o = hit_c[TABLE_ENTRIES].symbol;
        end else if (plen_q >= 6'(MAX_CODE_LEN)) begin
          status_o = ST_TOOLONG;
        end else begin
          status_o = ST_MORE;
        end
      end
      default: status_o = ST_CLEARED;
    endcase
  end

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
      timer_q <= '0;
      pend_q  <= '0;
      plen_q  <= '0;
      op_q    <= OP_RESTART;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      timer_q <= (state_q == FSM_SCAN) ? timer_q + CntW'(1) : '0;
      if (accept) begin
        op_q   <= operation_i;
        full_q <= full;
        case (operation_i)
          OP_LOAD:    if (!full) count_q <= count_q + CntW'(1);
          OP_DECODE: begin
            pend_q <= pbits[PendW-1:0];
            plen_q <= plen_new;
          end
          OP_CLEAR: begin
            count_q <= '0;
            pend_q  <= '0;
            plen_q  <= '0;
          end
          OP_RESTART: begin
            pend_q <= '0;
            plen_q <= '0;
          end
          default: ;
        endcase
      end
      // decode finished: empty accumulator on hit or overflow
      if (strobe && op_q == OP_DECODE &&
          (hit_c[TABLE_ENTRIES].hit || plen_q >= 6'(MAX_CODE_LEN))) begin
        pend_q <= '0;
        plen_q <= '0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_ENTRIES)) else $error("entry count overflow");
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy) else $error("strobe while idle");
  a_strobe_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |=> !busy) else $error("busy after result");
  a_plen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> plen_q < 6'(MAX_CODE_LEN)) else $error("accumulator not emptied");

endmodule
